/* rtl/dfq_pkg.sv */
// ============================================================================
// dfq_pkg - shared types and codes for the dedup FIFO queue
// Payload types, operation kinds, result status codes and the result struct.
// ============================================================================
`default_nettype none

package dfq_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [STATUS_W-1:0]       status_t;

    localparam logic KIND_ENQ = 1'b0;

    localparam status_t ST_ENQUEUED  = 3'd0;
    localparam status_t ST_DUPLICATE = 3'd1;
    localparam status_t ST_FULL      = 3'd2;
    localparam status_t ST_DEQUEUED  = 3'd3;
    localparam status_t ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic    valid;
        status_t status;
        value_t  value;
    } dfq_result_t;

endpackage

`default_nettype wire

/* rtl/dfq_if.sv */
// ============================================================================
// dfq_if - request and response channels
// Valid/ready channels carrying one operation item and one result item.
// ============================================================================
`default_nettype none

interface dfq_req_if
    import dfq_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   kind;
    value_t value_in;

    modport source (output valid, output kind, output value_in, input ready);
    modport sink   (input valid, input kind, input value_in, output ready);
endinterface

interface dfq_rsp_if
    import dfq_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t status;
    value_t  value_out;

    modport source (output valid, output status, output value_out, input ready);
    modport sink   (input valid, input status, input value_out, output ready);
endinterface

`default_nettype wire

/* rtl/dedup_fifo_queue.sv */
// ============================================================================
// dedup_fifo_queue - FIFO of signed 32-bit values that rejects duplicates
// Top level: sequencer, entry memory and the registered result stage.
// ============================================================================
// Enqueue into a non-empty, non-full queue scans the held entries from the
// head and stops at the first duplicate; otherwise the value is appended.
// Dequeue reads the head entry. Full, empty, or enqueue into an empty queue skip the scan.
// One item in flight; req.ready returns once the result enters the output
// register. Reset clears pointers, occupancy and valids; memory is not cleared.
`default_nettype none

module dedup_fifo_queue
    import dfq_pkg::*;
#(
    parameter int DEPTH = 512
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    dfq_req_if.sink   req,
    dfq_rsp_if.source rsp
);

    localparam int PTR_W = $clog2(DEPTH);

    dfq_result_t      res;
    logic             rsp_free;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    value_t           wr_data;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    value_t           rd_data;

    logic    out_valid_reg, out_valid_next;
    status_t out_status_reg, out_status_next;
    value_t  out_value_reg, out_value_next;

    dfq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp_free (rsp_free),
        .res      (res),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    dfq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rsp_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        if (res.valid)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res.status;
            out_value_next  = res.value;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.value_out = out_value_reg;

endmodule

`default_nettype wire

/* rtl/dfq_store.sv */
// ============================================================================
// dfq_store - entry memory
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module dfq_store
    import dfq_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int PTR_W = $clog2(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [PTR_W-1:0] wr_addr,
    input  wire value_t           wr_data,
    input  wire logic             rd_en,
    input  wire logic [PTR_W-1:0] rd_addr,
    output value_t                rd_data
);

    value_t mem [DEPTH];
    value_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/dfq_ctrl.sv */
// ============================================================================
// dfq_ctrl - queue sequencer
// Holds pointers and occupancy, scans held entries through the single
// comparator one per cycle, and issues appends and removals.
// ============================================================================
`default_nettype none

module dfq_ctrl
    import dfq_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int PTR_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    dfq_req_if.sink               req,
    input  wire logic             rsp_free,
    output dfq_result_t           res,
    output logic                  wr_en,
    output logic [PTR_W-1:0]      wr_addr,
    output value_t                wr_data,
    output logic                  rd_en,
    output logic [PTR_W-1:0]      rd_addr,
    input  wire value_t           rd_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DEQ  = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [1:0]       state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [PTR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             pend_reg, pend_next;
    value_t           value_reg, value_next;
    status_t          status_reg, status_next;
    value_t           res_value_reg, res_value_next;

    logic             issuing;
    logic             hit;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign issuing = (issue_cnt_reg != occ_reg);
    assign hit     = pend_reg && (rd_data == value_reg);

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        scan_ptr_next  = scan_ptr_reg;
        issue_cnt_next = issue_cnt_reg;
        pend_next      = 1'b0;
        value_next     = value_reg;
        status_next    = status_reg;
        res_value_next = res_value_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_reg;
        wr_data        = value_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_ptr_reg;
        res.valid      = 1'b0;
        res.status     = status_reg;
        res.value      = res_value_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    value_next = req.value_in;
                    if (req.kind == KIND_ENQ)
                    begin
                        if (occ_reg == CNT_FULL)
                        begin
                            status_next    = ST_FULL;
                            res_value_next = '0;
                            state_next     = S_RESP;
                        end
                        else if (occ_reg == '0)
                        begin
                            wr_en          = 1'b1;
                            wr_data        = req.value_in;
                            tail_next      = ptr_inc(tail_reg);
                            occ_next       = occ_reg + CNT_W'(1);
                            status_next    = ST_ENQUEUED;
                            res_value_next = req.value_in;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            scan_ptr_next  = head_reg;
                            issue_cnt_next = '0;
                            state_next     = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (occ_reg == '0)
                        begin
                            status_next    = ST_EMPTY;
                            res_value_next = '0;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = S_DEQ;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (issuing)
                begin
                    rd_en          = 1'b1;
                    scan_ptr_next  = ptr_inc(scan_ptr_reg);
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                pend_next = issuing;
                if (hit)
                begin
                    pend_next      = 1'b0;
                    status_next    = ST_DUPLICATE;
                    res_value_next = value_reg;
                    state_next     = S_RESP;
                end
                else if (!issuing)
                begin
                    wr_en          = 1'b1;
                    tail_next      = ptr_inc(tail_reg);
                    occ_next       = occ_reg + CNT_W'(1);
                    status_next    = ST_ENQUEUED;
                    res_value_next = value_reg;
                    state_next     = S_RESP;
                end
            end

            S_DEQ:
            begin
                head_next      = ptr_inc(head_reg);
                occ_next       = occ_reg - CNT_W'(1);
                status_next    = ST_DEQUEUED;
                res_value_next = rd_data;
                state_next     = S_RESP;
            end

            S_RESP:
            begin
                res.valid = rsp_free;
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            scan_ptr_reg  <= '0;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            scan_ptr_reg  <= scan_ptr_next;
            issue_cnt_reg <= issue_cnt_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        status_reg    <= status_next;
        res_value_reg <= res_value_next;
    end

    // head + occupancy must land on tail, modulo DEPTH
    logic [CNT_W:0] wrap_sum;
    logic [CNT_W:0] tail_expect;

    assign wrap_sum    = (CNT_W+1)'(head_reg) + (CNT_W+1)'(occ_reg);
    assign tail_expect = (wrap_sum >= (CNT_W+1)'(DEPTH)) ?
                         wrap_sum - (CNT_W+1)'(DEPTH) : wrap_sum;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_FULL)
        else $error("occupancy above depth");

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg == PTR_W'(tail_expect))
        else $error("tail does not match head plus occupancy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> rsp_free)
        else $error("result issued while output stage busy");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == ST_FULL) |-> occ_reg == CNT_FULL)
        else $error("full status with room left");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> issue_cnt_reg <= occ_reg)
        else $error("scan ran past occupancy");

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking bench for dedup_fifo_queue
// Drives enqueue and dequeue items over the request channel and tracks the
// queue contents in a small tracker class. Every result item is checked
// against the predicted status and value. Random traffic fills the queue to
// full, drains it to empty and then mixes both operations, under three
// sender/receiver idling mixes.
// ============================================================================

module tb;
    import dfq_pkg::*;

    localparam int   Q_DEPTH    = 512;
    localparam int   RAND_ITEMS = 1050;
    localparam logic KIND_DEQ   = !KIND_ENQ;

    typedef struct packed {
        status_t status;
        value_t  value;
    } outcome_t;

    class dedup_tracker;
        value_t   held[$];
        outcome_t due[$];
        int       depth;
        int       errors;

        function new(int d);
            depth  = d;
            errors = 0;
        endfunction

        function int held_count();
            return held.size();
        endfunction

        function value_t held_value(int idx);
            return held[idx];
        endfunction

        function int pending();
            return due.size();
        endfunction

        task report_mismatch(string what);
            if (errors < 40)
                $display("tb: mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void note_op(logic k, value_t v);
            outcome_t o;
            bit       found;
            o.status = ST_EMPTY;
            o.value  = '0;
            found    = 1'b0;
            if (k == KIND_ENQ) begin
                if (held.size() >= depth) begin
                    o.status = ST_FULL;
                end
                else begin
                    foreach (held[i])
                        if (held[i] == v)
                            found = 1'b1;
                    o.status = found ? ST_DUPLICATE : ST_ENQUEUED;
                    o.value  = v;
                    if (!found)
                        held.push_back(v);
                end
            end
            else if (held.size() != 0) begin
                o.status = ST_DEQUEUED;
                o.value  = held.pop_front();
            end
            due.push_back(o);
        endfunction

        task check_result(status_t s, value_t v);
            outcome_t o;
            if (due.size() == 0) begin
                report_mismatch($sformatf("result status %0d value %0d with none due", s, v));
                return;
            end
            o = due.pop_front();
            if (s !== o.status)
                report_mismatch($sformatf("status %0d, want %0d", s, o.status));
            if (v !== o.value)
                report_mismatch($sformatf("value %0d, want %0d (status %0d)",
                                          v, o.value, o.status));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;

    dedup_tracker trk;

    dfq_req_if req_ch();
    dfq_rsp_if rsp_ch();

    dedup_fifo_queue #(
        .DEPTH (Q_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
    end

    always @(negedge clk)
    begin
        rsp_ch.ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            trk.check_result(rsp_ch.status, rsp_ch.value_out);
    end

    task automatic send_op(input logic k, input value_t v);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.kind     = k;
        req_ch.value_in = v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        trk.note_op(k, v);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (trk.pending() != 0)
            @(negedge clk);
    endtask

    // held_pct: chance of re-sending a value already in the queue
    function automatic value_t pick_value(int held_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < held_pct && trk.held_count() > 0)
            return trk.held_value($urandom_range(0, trk.held_count() - 1));
        if (r < held_pct + 3) begin
            case ($urandom_range(0, 4))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 32'sh00000000;
                3: return 32'shffffffff;
                default: return 32'sh00000001;
            endcase
        end
        return $urandom;
    endfunction

    initial
    begin
        int     n;
        int     enq_pct;
        int     full_hits;
        int     empty_hits;
        bit     filling;
        bit     drained;
        value_t v;

        trk             = new(Q_DEPTH);
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.kind     = KIND_ENQ;
        req_ch.value_in = '0;
        tx_idle_pct     = 34;
        rx_idle_pct     = 88;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty, extremes, duplicates, reuse after dequeue
        send_op(KIND_DEQ, 32'sh7fffffff);
        send_op(KIND_ENQ, 32'sh7fffffff);
        send_op(KIND_ENQ, 32'sh80000000);
        send_op(KIND_ENQ, 32'sh00000000);
        send_op(KIND_ENQ, 32'shffffffff);
        send_op(KIND_ENQ, 32'sh00000001);
        send_op(KIND_ENQ, 32'sh7fffffff);
        send_op(KIND_ENQ, 32'shffffffff);
        send_op(KIND_ENQ, 32'sh00000001);
        send_op(KIND_DEQ, 32'sh00000000);
        send_op(KIND_DEQ, 32'shffffffff);
        send_op(KIND_ENQ, 32'sh7fffffff);
        send_op(KIND_ENQ, 32'sh80000000);
        send_op(KIND_ENQ, 32'sh00000000);
        send_op(KIND_DEQ, 32'sh80000000);
        send_op(KIND_DEQ, 32'sh55555555);
        send_op(KIND_DEQ, 32'shaaaaaaaa);
        send_op(KIND_DEQ, 32'sh00000000);
        send_op(KIND_DEQ, 32'sh12345678);
        send_op(KIND_DEQ, 32'shffffffff);
        send_op(KIND_DEQ, 32'sh7fffffff);

        // random: fill to full, drain to empty, then mixed traffic
        filling    = 1'b1;
        drained    = 1'b0;
        full_hits  = 0;
        empty_hits = 0;
        n          = 0;
        while (n < RAND_ITEMS || !drained) begin
            if (n == 380) begin
                wait_drained();
                tx_idle_pct = 88;
                rx_idle_pct = 34;
            end
            else if (n == 760) begin
                wait_drained();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (filling && trk.held_count() == Q_DEPTH)
                full_hits++;
            if (filling && full_hits >= 4)
                filling = 1'b0;
            if (!filling && !drained && trk.held_count() == 0)
                empty_hits++;
            if (!filling && empty_hits >= 4)
                drained = 1'b1;
            enq_pct = drained ? 50 : (filling ? 97 : 4);
            v = pick_value(filling ? 4 : 25);
            if ($urandom_range(0, 99) < enq_pct)
                send_op(KIND_ENQ, v);
            else
                send_op(KIND_DEQ, v);
            n++;
        end

        wait_drained();
        repeat (16) @(negedge clk);
        if (trk.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
